>>> rtl/npd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npd_pkg
// Shared constants, codes and types of the nested priority task dispatcher.
// ----------------------------------------------------------------------------
package npd_pkg;

   localparam int TASK_COUNT   = 16;
   localparam int STACK_MARGIN = 0;

   localparam int RAW_BITS  = TASK_COUNT - 1;
   localparam int TASK_BITS = (RAW_BITS > 15) ? 15 : ((RAW_BITS < 1) ? 1 : RAW_BITS);
   localparam int RAW_CAP   = TASK_COUNT + STACK_MARGIN;
   localparam int STACK_CAP = (RAW_CAP > 15) ? 15 : RAW_CAP;

   localparam int MASK_W      = 15;
   localparam int FUNC_W      = 2;
   localparam int INDEX_W     = 4;
   localparam int LEVEL_W     = 4;
   localparam int ERR_W       = 2;
   localparam int STACK_IDX_W = (STACK_CAP > 1) ? $clog2(STACK_CAP) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [MASK_W-1:0] TASK_MASK = MASK_W'((32'd1 << TASK_BITS) - 32'd1);

   typedef enum logic [FUNC_W-1:0] {
      OP_ACTIVATE = 2'd0,
      OP_SUSPEND  = 2'd1,
      OP_SCHEDULE = 2'd2,
      OP_TASK_END = 2'd3
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE      = 2'd0,
      ERR_OVERFLOW  = 2'd1,
      ERR_UNDERFLOW = 2'd2
   } err_type;

   typedef struct packed {
      op_type              op;
      logic [MASK_W-1:0]   bits;
   } item_type;

endpackage

>>> rtl/npd_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npd_channels
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface npd_req_if;
   logic                          valid;
   logic                          ready;
   logic [npd_pkg::FUNC_W-1:0]    func;
   logic [npd_pkg::MASK_W-1:0]    task_bits;

   modport source (output valid, output func, output task_bits, input ready);
   modport sink   (input valid, input func, input task_bits, output ready);
endinterface

interface npd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          dispatched;
   logic [npd_pkg::INDEX_W-1:0]   task_index;
   logic [npd_pkg::LEVEL_W-1:0]   nesting_depth;
   logic [npd_pkg::ERR_W-1:0]     error;
   logic [npd_pkg::MASK_W-1:0]    ready_bits;

   modport source (output valid, output dispatched, output task_index,
                   output nesting_depth, output error, output ready_bits, input ready);
   modport sink   (input valid, input dispatched, input task_index,
                   input nesting_depth, input error, input ready_bits, output ready);
endinterface

>>> rtl/npd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npd_front
// Accepts request items, decodes the function and trims the task mask.
// ----------------------------------------------------------------------------
module npd_front (
   input  logic              clock,
   input  logic              reset,
   npd_req_if.sink           req_chan,
   output logic              item_valid,
   output npd_pkg::item_type item,
   input  logic              item_ready
);

   logic              valid_ff;
   logic              valid_in;
   npd_pkg::item_type item_ff;
   npd_pkg::item_type item_in;
   logic              take;

   assign req_chan.ready = !valid_ff || item_ready;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      item_in.op   = npd_pkg::op_type'(req_chan.func);
      item_in.bits = req_chan.task_bits & npd_pkg::TASK_MASK;
      valid_in     = take || (valid_ff && !item_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/npd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npd_queue
// Short fifo between the decode front and the execution back.
// ----------------------------------------------------------------------------
module npd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  npd_pkg::item_type push_item,
   output logic              push_ready,
   output logic              pop_valid,
   output npd_pkg::item_type pop_item,
   input  logic              pop_ready
);

   npd_pkg::item_type                 slot_ff [npd_pkg::QUEUE_DEPTH];
   logic [npd_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [npd_pkg::QPTR_W-1:0]        wr_ptr_in;
   logic [npd_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [npd_pkg::QPTR_W-1:0]        rd_ptr_in;
   logic [npd_pkg::QCNT_W-1:0]        count_ff;
   logic [npd_pkg::QCNT_W-1:0]        count_in;
   logic                              push;
   logic                              pop;

   assign push_ready = count_ff != npd_pkg::QCNT_W'(npd_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == npd_pkg::QPTR_W'(npd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == npd_pkg::QPTR_W'(npd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/npd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npd_back
// Executes items against the ready mask, selectable mask and mask stack,
// and holds the response in an output register.
// ----------------------------------------------------------------------------
module npd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  npd_pkg::item_type item,
   output logic              item_ready,
   npd_rsp_if.source         rsp_chan
);

   logic [npd_pkg::MASK_W-1:0]   ready_ff;
   logic [npd_pkg::MASK_W-1:0]   ready_in;
   logic [npd_pkg::MASK_W-1:0]   sel_ff;
   logic [npd_pkg::MASK_W-1:0]   sel_in;
   logic [npd_pkg::LEVEL_W-1:0]  level_ff;
   logic [npd_pkg::LEVEL_W-1:0]  level_in;
   logic [npd_pkg::MASK_W-1:0]   saved_ff [npd_pkg::STACK_CAP];

   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic                         dispatched_ff;
   logic [npd_pkg::INDEX_W-1:0]  task_index_ff;
   logic [npd_pkg::INDEX_W-1:0]  task_index_in;
   logic [npd_pkg::LEVEL_W-1:0]  depth_ff;
   npd_pkg::err_type             error_ff;
   npd_pkg::err_type             error_in;
   logic [npd_pkg::MASK_W-1:0]   ready_bits_ff;

   logic                         fire;
   logic                         is_end;
   logic                         pop_ok;
   logic [npd_pkg::LEVEL_W-1:0]  level_pop;
   logic [npd_pkg::LEVEL_W-1:0]  level_p;
   logic [npd_pkg::MASK_W-1:0]   sel_p;
   logic                         do_check;
   logic                         overlap;
   logic                         full;
   logic                         go;
   logic [npd_pkg::INDEX_W-1:0]  top_k;
   logic [npd_pkg::MASK_W-1:0]   top_bit;
   logic [npd_pkg::MASK_W-1:0]   sel_above;

   assign item_ready = !out_valid_ff || rsp_chan.ready;
   assign fire       = item_valid && item_ready;

   // highest ready task
   always_comb begin
      top_k = '0;
      for (int i = 0; i < npd_pkg::TASK_BITS; i++) begin
         if (ready_ff[i]) begin
            top_k = npd_pkg::INDEX_W'(i);
         end
      end
      top_bit   = npd_pkg::MASK_W'(1) << top_k;
      sel_above = npd_pkg::TASK_MASK & ~((top_bit << 1) - npd_pkg::MASK_W'(1));
   end

   always_comb begin
      is_end    = item.op == npd_pkg::OP_TASK_END;
      pop_ok    = level_ff != '0;
      level_pop = level_ff - 1'b1;
      level_p   = level_ff;
      sel_p     = sel_ff;
      if (is_end && pop_ok) begin
         level_p = level_pop;
         sel_p   = saved_ff[level_pop[npd_pkg::STACK_IDX_W-1:0]];
      end
      do_check = (item.op == npd_pkg::OP_SCHEDULE) || (is_end && pop_ok);
      overlap  = (ready_ff & sel_p) != '0;
      full     = level_p >= npd_pkg::LEVEL_W'(npd_pkg::STACK_CAP);
      go       = do_check && overlap && !full;

      priority if (is_end && !pop_ok) begin
         error_in = npd_pkg::ERR_UNDERFLOW;
      end else if (do_check && overlap && full) begin
         error_in = npd_pkg::ERR_OVERFLOW;
      end else begin
         error_in = npd_pkg::ERR_NONE;
      end

      unique case (item.op)
         npd_pkg::OP_ACTIVATE: ready_in = ready_ff | item.bits;
         npd_pkg::OP_SUSPEND:  ready_in = ready_ff & ~item.bits;
         npd_pkg::OP_SCHEDULE,
         npd_pkg::OP_TASK_END: ready_in = go ? (ready_ff & ~top_bit) : ready_ff;
         default:              ready_in = ready_ff;
      endcase

      level_in      = go ? level_p + 1'b1 : level_p;
      sel_in        = go ? sel_above : sel_p;
      task_index_in = go ? top_k + 1'b1 : '0;
      out_valid_in  = fire || (out_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= '0;
         sel_ff       <= npd_pkg::TASK_MASK;
         level_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            ready_ff <= ready_in;
            sel_ff   <= sel_in;
            level_ff <= level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && go) begin
         saved_ff[level_p[npd_pkg::STACK_IDX_W-1:0]] <= sel_p;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         dispatched_ff <= go;
         task_index_ff <= task_index_in;
         depth_ff      <= level_in;
         error_ff      <= error_in;
         ready_bits_ff <= ready_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.dispatched    = dispatched_ff;
   assign rsp_chan.task_index    = task_index_ff;
   assign rsp_chan.nesting_depth = depth_ff;
   assign rsp_chan.error         = error_ff;
   assign rsp_chan.ready_bits    = ready_bits_ff;

endmodule

>>> rtl/nested_priority_task_dispatcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_priority_task_dispatcher_core
// Preemptive bitmask task dispatcher with a stack of saved selectable masks.
//
// req_chan carries one item per handshake: func (activate, suspend, schedule
// check, task end) and a task mask. rsp_chan returns exactly one item per
// request in order: dispatched flag, task index, nesting depth, error code
// and the ready mask after the request.
// path: a request passes the decode register and a queue slot, then execute
// writes the response into the output register
// throughput: one item per cycle while rsp_chan.ready is high; execute
// updates the masks and stack together, so items may follow back to back
// reset: ready mask cleared, selectable mask all tasks, stack empty, queue
// and output register empty
// stall: the output register holds the response while rsp_chan.ready is low;
// the queue and decode register absorb up to three more items before
// req_chan.ready drops
// ----------------------------------------------------------------------------
module nested_priority_task_dispatcher_core (
   input  logic      clock,
   input  logic      reset,
   npd_req_if.sink   req_chan,
   npd_rsp_if.source rsp_chan
);

   logic              front_valid;
   npd_pkg::item_type front_item;
   logic              front_ready;
   logic              back_valid;
   npd_pkg::item_type back_item;
   logic              back_ready;

   npd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item_valid (front_valid),
      .item       (front_item),
      .item_ready (front_ready)
   );

   npd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_item  (front_item),
      .push_ready (front_ready),
      .pop_valid  (back_valid),
      .pop_item   (back_item),
      .pop_ready  (back_ready)
   );

   npd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (back_valid),
      .item       (back_item),
      .item_ready (back_ready),
      .rsp_chan   (rsp_chan)
   );

endmodule

>>> rtl/npd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npd_checker
// Port-level checks of the dispatcher response stream.
// ----------------------------------------------------------------------------
module npd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_dispatched,
   input logic [npd_pkg::INDEX_W-1:0]   rsp_task_index,
   input logic [npd_pkg::LEVEL_W-1:0]   rsp_nesting_depth,
   input logic [npd_pkg::ERR_W-1:0]     rsp_error,
   input logic [npd_pkg::MASK_W-1:0]    rsp_ready_bits
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dispatched) &&
      $stable(rsp_task_index) && $stable(rsp_nesting_depth) &&
      $stable(rsp_error) && $stable(rsp_ready_bits))
      else $error("response changed while stalled");

   a_index_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dispatched == (rsp_task_index != '0))
      else $error("task index disagrees with dispatched flag");

   a_error_no_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error != npd_pkg::ERR_NONE |-> !rsp_dispatched)
      else $error("task started with an error");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error == npd_pkg::ERR_UNDERFLOW |-> rsp_nesting_depth == '0)
      else $error("underflow with nonempty stack");

   a_started_not_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dispatched |-> !rsp_ready_bits[rsp_task_index - 1'b1])
      else $error("started task still ready");

endmodule

bind nested_priority_task_dispatcher_core npd_checker u_npd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_dispatched    (rsp_chan.dispatched),
   .rsp_task_index    (rsp_chan.task_index),
   .rsp_nesting_depth (rsp_chan.nesting_depth),
   .rsp_error         (rsp_chan.error),
   .rsp_ready_bits    (rsp_chan.ready_bits)
);

>>> dv/tb_nested_priority_task_dispatcher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nested_priority_task_dispatcher_core
// Self-checking bench for the nested priority task dispatcher. A scoreboard
// class tracks the ready mask, selectable mask and saved-mask stack, predicts
// one response per accepted request, and compares every response field by
// field in order. Stimulus is a directed opener followed by random bursts,
// nesting ladders that fill the stack, and noise, under three idle profiles
// on the request and response sides.
// ----------------------------------------------------------------------------
module tb_nested_priority_task_dispatcher_core;

   localparam int CLK_PERIOD    = 8;
   localparam int RESET_CYCLES  = 9;
   localparam int PHASE_ITEMS   = 510;
   localparam int DRAIN_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PRINT_LIMIT   = 40;

   typedef struct packed {
      logic                          dispatched;
      logic [npd_pkg::INDEX_W-1:0]   task_index;
      logic [npd_pkg::LEVEL_W-1:0]   nesting_depth;
      npd_pkg::err_type              err_code;
      logic [npd_pkg::MASK_W-1:0]    ready_bits;
   } dispatch_rsp_type;

   class dispatch_scoreboard;
      logic [npd_pkg::MASK_W-1:0]    ready_mask;
      logic [npd_pkg::MASK_W-1:0]    select_mask;
      logic [npd_pkg::MASK_W-1:0]    saved_select [15];
      logic [npd_pkg::LEVEL_W-1:0]   level;
      dispatch_rsp_type              expected_rsp [$];
      int                            failures;
      int                            printed;
      int                            n_requests;
      int                            n_dispatched;
      int                            n_underflow;
      int                            n_overflow;
      int                            deepest;

      function new();
         ready_mask   = '0;
         select_mask  = npd_pkg::TASK_MASK;
         level        = '0;
         failures     = 0;
         printed      = 0;
         n_requests   = 0;
         n_dispatched = 0;
         n_underflow  = 0;
         n_overflow   = 0;
         deepest      = 0;
         foreach (saved_select[i]) saved_select[i] = '0;
      endfunction

      function int outstanding();
         return expected_rsp.size();
      endfunction

      function void note_request(npd_pkg::op_type op, logic [npd_pkg::MASK_W-1:0] bits_in);
         dispatch_rsp_type              exp;
         logic [npd_pkg::MASK_W-1:0]    bits;
         logic [npd_pkg::MASK_W-1:0]    top_bit;
         logic                          check;
         int                            k;
         bits  = bits_in & npd_pkg::TASK_MASK;
         exp   = '0;
         check = 1'b0;
         case (op)
            npd_pkg::OP_ACTIVATE: ready_mask = ready_mask | bits;
            npd_pkg::OP_SUSPEND:  ready_mask = ready_mask & ~bits & npd_pkg::TASK_MASK;
            npd_pkg::OP_SCHEDULE: check = 1'b1;
            default: begin
               if (level == 0) begin
                  exp.err_code = npd_pkg::ERR_UNDERFLOW;
               end else begin
                  level       = level - 1'b1;
                  select_mask = saved_select[level];
                  check       = 1'b1;
               end
            end
         endcase
         if (check && (ready_mask & select_mask) != '0) begin
            if (level >= npd_pkg::STACK_CAP) begin
               exp.err_code = npd_pkg::ERR_OVERFLOW;
            end else begin
               k = npd_pkg::TASK_BITS - 1;
               while (k > 0 && !ready_mask[k]) k--;
               top_bit             = npd_pkg::MASK_W'(1) << k;
               ready_mask          = ready_mask & ~top_bit & npd_pkg::TASK_MASK;
               saved_select[level] = select_mask;
               level               = level + 1'b1;
               select_mask         = ~((top_bit << 1) - npd_pkg::MASK_W'(1))
                                     & npd_pkg::TASK_MASK;
               exp.dispatched      = 1'b1;
               exp.task_index      = npd_pkg::INDEX_W'(k + 1);
            end
         end
         exp.nesting_depth = level;
         exp.ready_bits    = ready_mask;
         expected_rsp.push_back(exp);
         n_requests++;
         if (exp.dispatched) n_dispatched++;
         if (exp.err_code == npd_pkg::ERR_UNDERFLOW) n_underflow++;
         if (exp.err_code == npd_pkg::ERR_OVERFLOW) n_overflow++;
         if (int'(level) > deepest) deepest = int'(level);
      endfunction

      function void compare_field(string name, int unsigned e, int unsigned a);
         if (e != a) begin
            failures++;
            if (printed < PRINT_LIMIT) begin
               printed++;
               $display("%0t mismatch %s expected %0h actual %0h", $time, name, e, a);
            end
         end
      endfunction

      function void check_response(dispatch_rsp_type act);
         dispatch_rsp_type exp;
         if (expected_rsp.size() == 0) begin
            failures++;
            if (printed < PRINT_LIMIT) begin
               printed++;
               $display("%0t unexpected response, nothing pending, actual %0h", $time, act);
            end
         end else begin
            exp = expected_rsp.pop_front();
            compare_field("dispatched", exp.dispatched, act.dispatched);
            compare_field("task_index", exp.task_index, act.task_index);
            compare_field("nesting_depth", exp.nesting_depth, act.nesting_depth);
            compare_field("error", exp.err_code, act.err_code);
            compare_field("ready_bits", exp.ready_bits, act.ready_bits);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   npd_req_if req_if ();
   npd_rsp_if rsp_if ();

   nested_priority_task_dispatcher_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   dispatch_scoreboard sb;
   int send_idle;
   int recv_idle;
   int requests_sent;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic logic [npd_pkg::MASK_W-1:0] pick_task_bits();
      logic [npd_pkg::MASK_W-1:0] bits;
      case ($urandom_range(7))
         0:       bits = '0;
         1:       bits = npd_pkg::TASK_MASK;
         2, 3, 4: bits = npd_pkg::MASK_W'(1) << $urandom_range(npd_pkg::TASK_BITS - 1);
         5, 6:    bits = npd_pkg::MASK_W'($urandom);
         default: bits = (npd_pkg::MASK_W'(1) << $urandom_range(npd_pkg::TASK_BITS - 1))
                       | (npd_pkg::MASK_W'(1) << $urandom_range(npd_pkg::TASK_BITS - 1));
      endcase
      return bits;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(npd_pkg::op_type op, logic [npd_pkg::MASK_W-1:0] bits);
      while ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.func      <= op;
      req_if.task_bits <= bits;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(op, bits);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic run_directed();
      send_request(npd_pkg::OP_TASK_END, '0);
      send_request(npd_pkg::OP_SCHEDULE, '0);
      send_request(npd_pkg::OP_ACTIVATE, '0);
      send_request(npd_pkg::OP_ACTIVATE, npd_pkg::TASK_MASK);
      send_request(npd_pkg::OP_SCHEDULE, npd_pkg::TASK_MASK);
      send_request(npd_pkg::OP_SCHEDULE, '0);
      send_request(npd_pkg::OP_TASK_END, npd_pkg::TASK_MASK);
      send_request(npd_pkg::OP_SUSPEND, npd_pkg::TASK_MASK);
      send_request(npd_pkg::OP_TASK_END, '0);
      send_request(npd_pkg::OP_ACTIVATE, 15'h0001);
      send_request(npd_pkg::OP_SCHEDULE, '0);
      send_request(npd_pkg::OP_ACTIVATE, 15'h4000);
      send_request(npd_pkg::OP_SCHEDULE, '0);
      send_request(npd_pkg::OP_ACTIVATE, 15'h0002);
      send_request(npd_pkg::OP_SCHEDULE, '0);
      send_request(npd_pkg::OP_TASK_END, '0);
      send_request(npd_pkg::OP_TASK_END, '0);
      send_request(npd_pkg::OP_TASK_END, '0);
      send_request(npd_pkg::OP_TASK_END, '0);
      send_request(npd_pkg::OP_SUSPEND, '0);
      send_request(npd_pkg::OP_ACTIVATE, 15'h5555);
      send_request(npd_pkg::OP_SUSPEND, 15'h2AAA);
      send_request(npd_pkg::OP_SUSPEND, npd_pkg::TASK_MASK);
   endtask

   // nest one task per level with rising priority, then unwind part way
   task automatic run_ladder(int first_bit, int stride);
      int                         k;
      logic [npd_pkg::MASK_W-1:0] bits;
      while (sb.level != 0) send_request(npd_pkg::OP_TASK_END, pick_task_bits());
      send_request(npd_pkg::OP_SUSPEND, npd_pkg::TASK_MASK);
      k = first_bit;
      while (k < npd_pkg::TASK_BITS) begin
         bits = npd_pkg::MASK_W'(1) << k;
         if ($urandom_range(3) == 0) begin
            bits = bits | (npd_pkg::MASK_W'($urandom) & (bits - npd_pkg::MASK_W'(1)));
         end
         send_request(npd_pkg::OP_ACTIVATE, bits);
         send_request(npd_pkg::OP_SCHEDULE, pick_task_bits());
         k += stride;
      end
      send_request(npd_pkg::OP_SCHEDULE, pick_task_bits());
      repeat ($urandom_range(1, 18)) begin
         if ($urandom_range(99) < 70) send_request(npd_pkg::OP_TASK_END, pick_task_bits());
         else send_request(npd_pkg::OP_ACTIVATE, pick_task_bits());
      end
   endtask

   task automatic run_burst();
      int r;
      repeat ($urandom_range(4, 12)) begin
         r = $urandom_range(99);
         if (r < 30) send_request(npd_pkg::OP_ACTIVATE, pick_task_bits());
         else if (r < 45) send_request(npd_pkg::OP_SUSPEND, pick_task_bits());
         else if (r < 75) send_request(npd_pkg::OP_SCHEDULE, pick_task_bits());
         else send_request(npd_pkg::OP_TASK_END, pick_task_bits());
      end
   endtask

   task automatic run_random(int goal);
      int r;
      while (requests_sent < goal) begin
         r = $urandom_range(99);
         if (r < 35) begin
            run_ladder(($urandom_range(2) == 0) ? 0 : $urandom_range(npd_pkg::TASK_BITS - 1),
                       ($urandom_range(3) == 0) ? 2 : 1);
         end else if (r < 85) begin
            run_burst();
         end else begin
            repeat ($urandom_range(1, 6))
               send_request(npd_pkg::op_type'($urandom_range(3)),
                            npd_pkg::MASK_W'($urandom));
         end
      end
   endtask

   initial begin
      forever begin
         @(negedge clock);
         rsp_if.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin
      dispatch_rsp_type act;
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses pending",
                     cycle_count, sb.outstanding());
            $display("CHECKS FAILED");
            $finish;
         end
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            act.dispatched    = rsp_if.dispatched;
            act.task_index    = rsp_if.task_index;
            act.nesting_depth = rsp_if.nesting_depth;
            act.err_code      = npd_pkg::err_type'(rsp_if.error);
            act.ready_bits    = rsp_if.ready_bits;
            sb.check_response(act);
         end
      end
   end

   initial begin
      sb               = new();
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.func      = npd_pkg::OP_ACTIVATE;
      req_if.task_bits = '0;
      rsp_if.ready     = 1'b0;
      send_idle        = 29;
      recv_idle        = 63;
      requests_sent    = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      run_ladder(0, 1);
      run_random(PHASE_ITEMS);

      send_idle = 63;
      recv_idle = 29;
      run_random(2 * PHASE_ITEMS);

      send_idle = 0;
      recv_idle = 0;
      run_random(3 * PHASE_ITEMS);

      req_if.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d dispatches, %0d underflows, %0d overflows",
               sb.n_requests, sb.n_dispatched, sb.n_underflow, sb.n_overflow);
      $display("deepest nesting %0d of %0d, %0d field mismatches",
               sb.deepest, npd_pkg::STACK_CAP, sb.failures);
      if (sb.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
